// ===== hw/rtl/owcrc8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owcrc8_pkg
// Types, constants and the CRC-8 function of the single-wire transceiver.
// ----------------------------------------------------------------------------
package owcrc8_pkg;

   localparam int unsigned REQUEST_BITS      = 16;
   localparam int unsigned RESPONSE_BITS_DEF = 32;
   localparam int unsigned WORD_W            = 32;
   localparam int unsigned CNT_W             = 6;
   localparam logic [7:0]  CRC_POLY          = 8'h07;
   localparam logic [7:0]  CRC_SEED_RESET    = 8'hAC;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_START    = 6'b000010,
      PH_REQUEST  = 6'b000100,
      PH_WAITING  = 6'b001000,
      PH_RESPONSE = 6'b010000,
      PH_STOPPING = 6'b100000
   } phase_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] seed, input logic [7:0] v);
      logic [7:0] c;
      c = seed ^ v;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/one_wire_crc8_request_response.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_crc8_request_response
// Single-wire request/response transceiver with CRC-8, stepped by bit ticks.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser contents
//  req_    | in        | tdata: request_byte[7:0], line_sample[8]; tuser: operation
//  rsp_    | out       | tdata: line_level[0], line_drive[1], session_busy[2],
//          |           |        response_valid[3], response_word[35:4]
//  csr_    | in        | data: crc_seed[7:0]
//
//  One transaction per cycle while req_tready is high; each start or tick is
//  done in the accept cycle; its result goes to the output register or the skid.
//  A two-entry output buffer (output register plus skid) keeps req_tready
//  registered; input stalls only when both entries hold results.
//  Synchronous active-high reset: phase idle, line driven high, crc_seed 0xAC.
// ----------------------------------------------------------------------------
module one_wire_crc8_request_response
   import owcrc8_pkg::*;
#(
   parameter int unsigned RESPONSE_BITS = RESPONSE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // request_byte[7:0], line_sample[8]
   input  logic                  req_tuser,   // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // level, drive, busy, valid, word[35:4]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data
);

   logic [7:0]         crc_seed_ff;
   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_dec;
   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic               level_ff, level_in;
   logic               drive_ff, drive_in;
   logic               rvalid_in;
   logic [WORD_W-1:0]  rword_in;
   logic [7:0]         crc;
   logic               req_fire;
   logic [RSP_DATA_W-1:0] result;

   logic                  out_valid_ff, skid_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, skid_data_ff;

   assign csr_ready = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign req_fire = req_tvalid && req_tready;
   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign crc = crc8_byte(crc_seed_ff, req_tdata[7:0]);

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      level_in  = level_ff;
      drive_in  = drive_ff;
      rvalid_in = 1'b0;
      rword_in  = '0;
      if (req_tuser == OP_START) begin
         phase_in = PH_START;
         shift_in = {req_tdata[7:0], crc, {(WORD_W - REQUEST_BITS){1'b0}}};
         cnt_in   = CNT_W'(1);
         drive_in = 1'b1;
         level_in = 1'b0;
      end else begin
         case (phase_ff)
            PH_START: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  cnt_in   = CNT_W'(REQUEST_BITS);
                  phase_in = PH_REQUEST;
               end
            end
            PH_REQUEST: begin
               cnt_in   = cnt_dec;
               level_in = shift_ff[WORD_W-1];
               shift_in = {shift_ff[WORD_W-2:0], 1'b0};
               if (cnt_dec == '0) begin
                  cnt_in   = CNT_W'(2);
                  phase_in = PH_WAITING;
               end
            end
            PH_WAITING: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  cnt_in   = CNT_W'(RESPONSE_BITS);
                  phase_in = PH_RESPONSE;
               end else if (cnt_dec == CNT_W'(1)) begin
                  drive_in = 1'b0;
                  level_in = 1'b1;
               end
            end
            PH_RESPONSE: begin
               cnt_in   = cnt_dec;
               shift_in = {shift_ff[WORD_W-2:0], req_tdata[8]};
               if (cnt_dec == '0) begin
                  cnt_in    = CNT_W'(2);
                  phase_in  = PH_STOPPING;
                  level_in  = 1'b1;
                  drive_in  = 1'b1;
                  rvalid_in = 1'b1;
                  rword_in  = shift_in;
               end
            end
            PH_STOPPING: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   assign result = {4'b0, rword_in, rvalid_in, (phase_in != PH_IDLE), drive_in, level_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_seed_ff <= CRC_SEED_RESET;
         phase_ff    <= PH_IDLE;
         cnt_ff      <= '0;
         shift_ff    <= '0;
         level_ff    <= 1'b1;
         drive_ff    <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            crc_seed_ff <= csr_data;
         end
         if (req_fire) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            shift_ff <= shift_in;
            level_ff <= level_in;
            drive_ff <= drive_in;
         end
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_tready) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= req_fire;
            end
         end else if (req_fire) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (req_fire) begin
            out_data_ff <= result;
         end
      end else if (req_fire) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_idle_line_high: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (level_ff && drive_ff))
      else $error("line not driven high while idle");

   a_valid_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> (rsp_tdata[2:0] == 3'b111))
      else $error("response completes without stop phase and high drive");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[3]) |-> (rsp_tdata[35:4] == '0))
      else $error("response word nonzero outside the completing tick");

endmodule

// ===== tb/sv/owcrc8_line_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owcrc8_line_checker
// Watches the request, response and seed channels of the single-wire CRC-8
// transceiver. Each accepted request transaction is run through a local model
// of the session sequencer (start, request bits, wait, response bits, stop)
// and the expected line result is queued; every accepted response transaction
// is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module owcrc8_line_checker
   import owcrc8_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // request_byte[7:0], line_sample[8]
   input  logic                  req_tuser,   // operation
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // level, drive, busy, valid, word[35:4]
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [7:0]            csr_data,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] word;
      logic        valid;
      logic        busy;
      logic        drive;
      logic        level;
   } line_result_type;

   line_result_type  line_results_due[$];
   int               fail_total = 0;
   int               due_count  = 0;

   phase_type        ph;
   logic [CNT_W-1:0] bits_left;
   logic [31:0]      shreg;
   logic             lvl;
   logic             drv;
   logic [7:0]       seed;

   assign fail_count  = fail_total;
   assign outstanding = due_count;

   function automatic logic [7:0] crc8_serial(input logic [7:0] init, input logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = init;
      for (int k = 7; k >= 0; k--) begin
         fb = r[7] ^ data[k];
         r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   task automatic clear_transceiver();
      ph        = PH_IDLE;
      bits_left = '0;
      shreg     = '0;
      lvl       = 1'b1;
      drv       = 1'b1;
      seed      = CRC_SEED_RESET;
   endtask

   task automatic step_transceiver(input logic op, input logic [7:0] cmd, input logic smp,
                                   output line_result_type res);
      res = '0;
      if (op == OP_START) begin
         shreg     = {cmd, crc8_serial(seed, cmd), 16'h0000};
         ph        = PH_START;
         bits_left = CNT_W'(1);
         drv       = 1'b1;
         lvl       = 1'b0;
      end else if (ph != PH_IDLE) begin
         bits_left = bits_left - CNT_W'(1);
         case (ph)
            PH_START: begin
               if (bits_left == '0) begin
                  bits_left = CNT_W'(REQUEST_BITS);
                  ph        = PH_REQUEST;
               end
            end
            PH_REQUEST: begin
               lvl   = shreg[31];
               shreg = shreg << 1;
               if (bits_left == '0) begin
                  bits_left = CNT_W'(2);
                  ph        = PH_WAITING;
               end
            end
            PH_WAITING: begin
               if (bits_left == '0) begin
                  bits_left = CNT_W'(RESPONSE_BITS_DEF);
                  ph        = PH_RESPONSE;
               end else if (bits_left == CNT_W'(1)) begin
                  drv = 1'b0;
                  lvl = 1'b1;
               end
            end
            PH_RESPONSE: begin
               shreg = {shreg[30:0], smp};
               if (bits_left == '0) begin
                  bits_left = CNT_W'(2);
                  ph        = PH_STOPPING;
                  lvl       = 1'b1;
                  drv       = 1'b1;
                  res.valid = 1'b1;
                  res.word  = shreg;
               end
            end
            default: begin
               if (bits_left == '0) begin
                  ph = PH_IDLE;
               end
            end
         endcase
      end
      res.level = lvl;
      res.drive = drv;
      res.busy  = (ph != PH_IDLE);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_total < 100) begin
         $display("mismatch %s: got %h, want %h at %0t ns", what, got, want, $time);
      end
      fail_total++;
   endtask

   always @(posedge clock) begin
      line_result_type got;
      line_result_type want;
      if (reset) begin
         clear_transceiver();
         line_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            seed = csr_data;
         end
         if (req_tvalid && req_tready) begin
            step_transceiver(req_tuser, req_tdata[7:0], req_tdata[8], want);
            line_results_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (line_results_due.size() == 0) begin
               report_mismatch("unrequested response transaction", got.word, '0);
            end else begin
               want = line_results_due.pop_front();
               if (got.level !== want.level)
                  report_mismatch("line_level", 32'(got.level), 32'(want.level));
               if (got.drive !== want.drive)
                  report_mismatch("line_drive", 32'(got.drive), 32'(want.drive));
               if (got.busy !== want.busy)
                  report_mismatch("session_busy", 32'(got.busy), 32'(want.busy));
               if (got.valid !== want.valid)
                  report_mismatch("response_valid", 32'(got.valid), 32'(want.valid));
               if (got.word !== want.word)
                  report_mismatch("response_word", got.word, want.word);
               if (got.pad !== want.pad)
                  report_mismatch("tdata pad", 32'(got.pad), 32'(want.pad));
            end
         end
      end
      due_count = line_results_due.size();
   end

endmodule

// ===== tb/sv/tb_one_wire_crc8_request_response.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_crc8_request_response
// Drives start and tick transactions into the single-wire CRC-8 transceiver:
// a short directed sequence at the reset seed, then phases of random sessions
// (full, cut short by a restart, and stray ticks) under several CRC seeds.
// The sender runs in bursts, the receiver stalls on its own schedule and once
// holds off long enough to back up the input. A checker module does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_one_wire_crc8_request_response;
   import owcrc8_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // request_byte[7:0], line_sample[8]
   logic                  req_tuser;   // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // level, drive, busy, valid, word[35:4]
   logic                  csr_valid;
   logic                  csr_ready;
   logic [7:0]            csr_data;

   int fail_count;
   int outstanding;
   int burst_left  = 0;
   int phase_items = 0;
   bit gaps_on     = 1'b1;
   bit hold_rsp    = 1'b0;

   one_wire_crc8_request_response uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   owcrc8_line_checker line_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_item(input logic op, input logic [7:0] cmd, input logic smp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_tvalid = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      burst_left--;
      req_tvalid     = 1'b1;
      req_tuser      = op;
      req_tdata      = '0;
      req_tdata[7:0] = cmd;
      req_tdata[8]   = smp;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic load_crc_seed(input logic [7:0] value);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Ticks 19..50 of a session sample the response, MSB first.
   task automatic play_session(input bit cut_short, input int pattern_kind);
      int          ticks;
      logic [31:0] reply;
      logic        smp;
      ticks = cut_short ? $urandom_range(0, 52) : 53 + $urandom_range(0, 3);
      case (pattern_kind)
         0:       reply = 32'h0000_0000;
         1:       reply = 32'hFFFF_FFFF;
         2:       reply = 32'hAAAA_AAAA ^ {32{1'($urandom_range(0, 1))}};
         default: reply = $urandom;
      endcase
      send_item(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < ticks; i++) begin
         smp = (i >= 19 && i <= 50) ? reply[50 - i] : 1'($urandom_range(0, 1));
         send_item(OP_TICK, 8'($urandom_range(0, 255)), smp);
      end
      phase_items += ticks + 1;
   endtask

   initial begin
      int          hold_cycles;
      int          mode;
      int          rx_cycle;
      logic [15:0] stall_pattern;
      rsp_tready    = 1'b0;
      mode          = 0;
      rx_cycle      = 0;
      stall_pattern = 16'b1011_0111_0010_1101;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle % 128 == 0) begin
            mode = $urandom_range(0, 3);
         end
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            for (hold_cycles = 0; hold_cycles < 80; hold_cycles++) @(negedge clock);
            hold_rsp = 1'b0;
         end
         case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = stall_pattern[rx_cycle % 16];
            2:       rsp_tready = ($urandom_range(0, 3) != 0);
            default: rsp_tready = 1'($urandom_range(0, 1));
         endcase
      end
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_TICK;
      csr_valid  = 1'b0;
      csr_data   = 8'h00;
      reset      = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ticks while idle, then starts interrupting one another
      send_item(OP_TICK, 8'hFF, 1'b1);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_START, 8'h00, 1'b1);
      send_item(OP_TICK, 8'hFF, 1'b1);
      send_item(OP_TICK, 8'hFF, 1'b1);
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_START, 8'hFF, 1'b0);
      send_item(OP_TICK, 8'h55, 1'b1);
      send_item(OP_TICK, 8'hAA, 1'b0);
      send_item(OP_START, 8'h80, 1'b1);
      send_item(OP_TICK, 8'h00, 1'b1);
      send_item(OP_START, 8'h01, 1'b0);
      send_item(OP_START, 8'h7F, 1'b1);
      send_item(OP_TICK, 8'hFF, 1'b0);
      play_session(1'b0, 1);
      play_session(1'b0, 0);
      send_item(OP_TICK, 8'hFF, 1'b1);
      wait_for_responses();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       load_crc_seed(8'h00);
            1:       load_crc_seed(8'hFF);
            3:       load_crc_seed(8'h80);
            default: load_crc_seed(8'($urandom_range(0, 255)));
         endcase
         gaps_on = (p != 3);
         if (p == 1) begin
            hold_rsp = 1'b1;
         end
         phase_items = 0;
         while (phase_items < 40) begin
            case ($urandom_range(0, 9))
               0: begin
                  repeat ($urandom_range(1, 4))
                     send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
               1, 2:    play_session(1'b1, $urandom_range(0, 4));
               default: play_session(1'b0, $urandom_range(0, 4));
            endcase
         end
         play_session(1'b0, $urandom_range(0, 4));
         wait_for_responses();
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
